// ----- hw/rtl/tsmerge_pkg.sv -----
package tsmerge_pkg;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_LOST  = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;
    localparam logic [1:0] ACT_POP   = 2'd3;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_PLACED   = 3'd2;
    localparam logic [2:0] ST_NO_ROOM  = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    localparam logic [1:0] REG_BUFFER_BYTES = 2'd0;
    localparam logic [1:0] REG_HEADER_BYTES = 2'd1;
    localparam logic [1:0] REG_RECORD_BYTES = 2'd2;
    localparam logic [1:0] REG_INLINE_MAX   = 2'd3;

    typedef struct packed {
        logic [15:0] buffer_bytes;
        logic [9:0]  header_bytes;
        logic [6:0]  record_bytes;
        logic [6:0]  inline_max;
    } t_cfg;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

// ----- hw/rtl/tsmerge_cfg.sv -----
module tsmerge_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tsmerge_pkg::t_cfg  o_cfg
);
    import tsmerge_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffer_bytes <= 16'd32768;
            r_cfg.header_bytes <= 10'd24;
            r_cfg.record_bytes <= 7'd12;
            r_cfg.inline_max   <= 7'd4;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_BUFFER_BYTES: r_cfg.buffer_bytes <= pwdata[15:0];
                REG_HEADER_BYTES: r_cfg.header_bytes <= pwdata[9:0];
                REG_RECORD_BYTES: r_cfg.record_bytes <= pwdata[6:0];
                REG_INLINE_MAX:   r_cfg.inline_max   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BUFFER_BYTES: prdata = {16'd0, r_cfg.buffer_bytes};
            REG_HEADER_BYTES: prdata = {22'd0, r_cfg.header_bytes};
            REG_RECORD_BYTES: prdata = {25'd0, r_cfg.record_bytes};
            REG_INLINE_MAX:   prdata = {25'd0, r_cfg.inline_max};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ----- hw/rtl/timestamp_event_merge.sv -----
// Time-ordered merge of up to SOURCES event queues of EVENTS_PER_SOURCE entries each into
// a byte buffer that fills from its top. Issue a command by raising start while busy is
// low; every command gives exactly one result beat, o_valid high for one cycle, and busy
// drops in that same cycle, so the next command may follow at once. Load, lost and start
// commands pass through S_SIMPLE to the result beat. A pop runs S_SCAN, where one
// comparator walks the source heads one per cycle through the single read port of the
// queue memory, then S_TAIL compares the last head, and S_NEED, S_LEFT and S_PLACE form
// the space need, check the room and place the event. A pop that finds no queued head
// answers from S_NEED, and so does a pop after the merge stopped, which skips the scan.
// Results cannot be held off by the receiver. Queue contents need no clearing, so the
// block is ready right after reset.
module timestamp_event_merge #(
    parameter int SOURCES           = 8,
    parameter int EVENTS_PER_SOURCE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_source,
    input  logic [15:0] i_time_req,
    input  logic [15:0] i_size,
    input  logic [15:0] i_lost_count,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [2:0]  o_out_source,
    output logic [5:0]  o_source_position,
    output logic [15:0] o_out_time,
    output logic [15:0] o_out_size,
    output logic        o_is_inline,
    output logic [15:0] o_data_offset,
    output logic [9:0]  o_mixed_count,
    output logic [15:0] o_lost_total
);
    import tsmerge_pkg::*;

    localparam int SW    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int RW    = $clog2(EVENTS_PER_SOURCE + 1);
    localparam int DEPTH = SOURCES * EVENTS_PER_SOURCE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RSW   = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SIMPLE, S_SCAN, S_TAIL, S_NEED, S_LEFT, S_PLACE
    } t_state;

    t_cfg cfg;

    tsmerge_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    t_state          r_state;
    logic [1:0]      r_act;
    logic            r_bad;
    logic [SW-1:0]   r_idx;
    logic [15:0]     r_in_time;
    logic [15:0]     r_in_size;
    logic [15:0]     r_in_lost;
    logic [RW-1:0]   r_fill [SOURCES];
    logic [RW-1:0]   r_read [SOURCES];
    logic [9:0]      r_mix;
    logic [15:0]     r_wp;
    logic [15:0]     r_lost;
    logic            r_stopped;
    logic            r_pend_valid;
    logic [SW-1:0]   r_pend_src;
    logic [RW-1:0]   r_pend_pos;
    logic            r_found;
    logic [SW-1:0]   r_best_src;
    logic [RW-1:0]   r_best_pos;
    logic [15:0]     r_best_time;
    logic [15:0]     r_best_size;
    logic [RSW-1:0]  r_rest;
    logic [19:0]     r_need;
    logic            r_fail;

    logic [31:0]     r_mem [DEPTH];
    logic [31:0]     r_rdata;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    logic [AW-1:0]   src_base;
    logic            head_ok;
    logic            take_pend;
    logic            full_c;
    logic signed [20:0] left_c;
    logic            fail_c;
    logic [15:0]     n_wp;
    logic [9:0]      n_mix;

    assign busy      = (r_state != S_IDLE);
    assign src_base  = AW'(r_idx * EVENTS_PER_SOURCE);
    assign head_ok   = r_read[r_idx] < r_fill[r_idx];
    assign full_c    = r_fill[r_idx] >= RW'(EVENTS_PER_SOURCE);
    assign mem_we    = (r_state == S_SIMPLE) && (r_act == ACT_LOAD) && !r_bad && !full_c;
    assign mem_waddr = AW'(src_base + AW'(r_fill[r_idx]));
    assign mem_raddr = AW'(src_base + AW'(r_read[r_idx]));
    assign take_pend = r_pend_valid && (!r_found || (r_rdata[31:16] < r_best_time));

    assign left_c = $signed({5'd0, cfg.buffer_bytes}) - $signed({1'b0, r_need});
    always_comb begin
        if (left_c < 0) begin
            fail_c = 1'b1;
        end else if (left_c <= $signed({14'd0, cfg.inline_max})) begin
            fail_c = (cfg.inline_max == 7'd0) || (r_best_size > {9'd0, cfg.inline_max});
        end else begin
            fail_c = $signed({5'd0, r_best_size}) > left_c;
        end
    end

    assign n_wp  = r_wp + r_best_size;
    assign n_mix = (r_mix == 10'd1023) ? r_mix : r_mix + 10'd1;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= {r_in_time, r_in_size};
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_act        <= ACT_LOAD;
            r_bad        <= 1'b0;
            r_idx        <= '0;
            for (int i = 0; i < SOURCES; i++) begin
                r_fill[i] <= '0;
                r_read[i] <= '0;
            end
            r_mix        <= '0;
            r_wp         <= '0;
            r_lost       <= '0;
            r_stopped    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_found      <= 1'b0;
            r_rest       <= '0;
            r_fail       <= 1'b0;
            o_valid      <= 1'b0;
            o_status     <= ST_ACCEPTED;
            o_out_source <= '0;
            o_source_position <= '0;
            o_out_time   <= '0;
            o_out_size   <= '0;
            o_is_inline  <= 1'b0;
            o_data_offset <= '0;
            o_mixed_count <= '0;
            o_lost_total <= '0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_act        <= i_action;
                        r_bad        <= 32'(i_source) >= SOURCES;
                        r_idx        <= (i_action == ACT_POP) ? '0 : SW'(i_source);
                        r_in_time    <= i_time_req;
                        r_in_size    <= i_size;
                        r_in_lost    <= i_lost_count;
                        r_pend_valid <= 1'b0;
                        r_found      <= 1'b0;
                        r_rest       <= '0;
                        if (i_action != ACT_POP) begin
                            r_state <= S_SIMPLE;
                        end else if (r_stopped) begin
                            r_state <= S_NEED;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SIMPLE: begin
                    o_valid           <= 1'b1;
                    o_status          <= ST_ACCEPTED;
                    o_out_source      <= '0;
                    o_source_position <= '0;
                    o_out_time        <= '0;
                    o_out_size        <= '0;
                    o_is_inline       <= 1'b0;
                    o_data_offset     <= '0;
                    o_mixed_count     <= r_mix;
                    o_lost_total      <= r_lost;
                    case (r_act)
                        ACT_LOAD: begin
                            if (r_bad || full_c) begin
                                o_status <= ST_FULL;
                            end else begin
                                r_fill[r_idx] <= r_fill[r_idx] + RW'(1);
                            end
                        end
                        ACT_LOST: begin
                            r_lost       <= sat_add16(r_lost, r_in_lost);
                            o_lost_total <= sat_add16(r_lost, r_in_lost);
                        end
                        ACT_START: begin
                            for (int i = 0; i < SOURCES; i++) begin
                                r_read[i] <= '0;
                            end
                            r_mix         <= '0;
                            r_wp          <= '0;
                            r_lost        <= '0;
                            r_stopped     <= 1'b0;
                            o_mixed_count <= '0;
                            o_lost_total  <= '0;
                        end
                        default: ;
                    endcase
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    if (take_pend) begin
                        r_found     <= 1'b1;
                        r_best_src  <= r_pend_src;
                        r_best_pos  <= r_pend_pos;
                        r_best_time <= r_rdata[31:16];
                        r_best_size <= r_rdata[15:0];
                    end
                    r_pend_valid <= head_ok;
                    r_pend_src   <= r_idx;
                    r_pend_pos   <= r_read[r_idx];
                    r_rest       <= r_rest + RSW'(r_fill[r_idx] - r_read[r_idx]);
                    if (r_idx == SW'(SOURCES - 1)) begin
                        r_state <= S_TAIL;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
                S_TAIL: begin
                    if (take_pend) begin
                        r_found     <= 1'b1;
                        r_best_src  <= r_pend_src;
                        r_best_pos  <= r_pend_pos;
                        r_best_time <= r_rdata[31:16];
                        r_best_size <= r_rdata[15:0];
                    end
                    r_state <= S_NEED;
                end
                S_NEED: begin
                    r_idx  <= r_best_src;
                    r_need <= 20'(cfg.header_bytes)
                            + 20'(18'(cfg.record_bytes) * 18'({1'b0, r_mix} + 11'd1))
                            + 20'(r_wp);
                    if (!r_found) begin
                        o_valid           <= 1'b1;
                        o_status          <= ST_DONE;
                        o_out_source      <= '0;
                        o_source_position <= '0;
                        o_out_time        <= '0;
                        o_out_size        <= '0;
                        o_is_inline       <= 1'b0;
                        o_data_offset     <= '0;
                        o_mixed_count     <= r_mix;
                        o_lost_total      <= r_lost;
                        r_state           <= S_IDLE;
                    end else begin
                        r_state <= S_LEFT;
                    end
                end
                S_LEFT: begin
                    r_fail  <= fail_c;
                    r_state <= S_PLACE;
                end
                S_PLACE: begin
                    o_valid           <= 1'b1;
                    o_out_source      <= 3'(r_best_src);
                    o_source_position <= 6'(r_best_pos);
                    o_out_time        <= r_best_time;
                    o_out_size        <= r_best_size;
                    o_is_inline       <= 1'b0;
                    o_data_offset     <= '0;
                    if (r_fail) begin
                        r_lost        <= sat_add16(r_lost, 16'(r_rest));
                        r_stopped     <= 1'b1;
                        o_status      <= ST_NO_ROOM;
                        o_mixed_count <= r_mix;
                        o_lost_total  <= sat_add16(r_lost, 16'(r_rest));
                    end else begin
                        r_mix         <= n_mix;
                        r_read[r_idx] <= r_read[r_idx] + RW'(1);
                        o_status      <= ST_PLACED;
                        o_mixed_count <= n_mix;
                        o_lost_total  <= r_lost;
                        if (r_best_size <= {9'd0, cfg.inline_max}) begin
                            o_is_inline <= 1'b1;
                        end else begin
                            r_wp          <= n_wp;
                            o_data_offset <= cfg.buffer_bytes - n_wp;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_valid_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result beat without a command in flight");

    a_busy_falls_with_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("command finished without a result beat");

    a_start_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not start");

    a_placed_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_PLACED |-> o_mixed_count != 10'd0)
        else $error("placed event not counted");

    a_stopped_no_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_NO_ROOM |=> r_stopped)
        else $error("merge not stopped after no room");
`endif

endmodule
